// File: src/dtts_pkg.sv
package dtts_pkg;

    localparam int TICK_W = 64;
    localparam int ID_W   = 5;
    localparam int OP_W   = 3;
    localparam int KIND_W = 3;

    localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
    localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
    localparam logic [OP_W-1:0] OP_PLAN_NOW   = 3'd2;
    localparam logic [OP_W-1:0] OP_PLAN_ABS   = 3'd3;
    localparam logic [OP_W-1:0] OP_PLAN_REL   = 3'd4;
    localparam logic [OP_W-1:0] OP_PLAN_FROM  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPIN       = 3'd6;

    localparam logic [KIND_W-1:0] KIND_REGISTERED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACK        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DUE        = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd4;

    localparam logic [TICK_W-1:0] TICK_ALL_ONES = '1;

    typedef struct packed {
        logic claim;
        logic drop;
    } t_slot_cmd;

endpackage

// File: src/dtts_due_mem.sv
module dtts_due_mem
    import dtts_pkg::*;
#(
    parameter int NUM_SLOTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_wr_addr,
    input  logic [TICK_W-1:0]            i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_rd_addr,
    output logic [TICK_W-1:0]            o_rd_data
);

    logic [TICK_W-1:0] r_mem [NUM_SLOTS];
    logic [TICK_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/dtts_slot_map.sv
module dtts_slot_map
    import dtts_pkg::*;
#(
    parameter int NUM_SLOTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_slot_cmd                    i_cmd,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_idx,
    output logic [NUM_SLOTS-1:0]         o_in_use,
    output logic [$clog2(NUM_SLOTS)-1:0] o_highest,
    output logic                         o_free_found,
    output logic [$clog2(NUM_SLOTS)-1:0] o_free_idx
);

    localparam int AW = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] r_in_use;
    logic [NUM_SLOTS-1:0] n_in_use;
    logic [AW-1:0]        r_highest;
    logic [AW-1:0]        n_highest;
    logic [AW-1:0]        below_idx;
    logic [AW-1:0]        free_idx;
    logic                 free_found;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
            if (!r_in_use[j]) begin
                free_found = 1'b1;
                free_idx   = AW'(j);
            end
        end
    end

    always_comb begin
        below_idx = '0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if ((AW'(j) < i_idx) && r_in_use[j]) begin
                below_idx = AW'(j);
            end
        end
    end

    always_comb begin
        n_in_use  = r_in_use;
        n_highest = r_highest;
        if (i_cmd.claim) begin
            n_in_use[i_idx] = 1'b1;
            if (r_highest < i_idx) begin
                n_highest = i_idx;
            end
        end else if (i_cmd.drop) begin
            n_in_use[i_idx] = 1'b0;
            if (r_highest == i_idx) begin
                n_highest = below_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use  <= '0;
            r_highest <= '0;
        end else begin
            r_in_use  <= n_in_use;
            r_highest <= n_highest;
        end
    end

    assign o_in_use     = r_in_use;
    assign o_highest    = r_highest;
    assign o_free_found = free_found;
    assign o_free_idx   = free_idx;

endmodule

// File: src/deadline_task_table_scheduler.sv
// Deadline task table scheduler.
// The request channel (i_in_valid, o_in_stall) carries one operation at a
// time: register, unregister, four plan forms, or spin. A request is taken
// when i_in_valid is high and o_in_stall is low; o_in_stall stays high from
// the cycle after acceptance until the block has queued its last result.
// The result channel (o_out_valid, i_out_stall) delivers results from an
// output register; o_last marks the final result of each request.
// A non-spin request passes through the execute state, which loads its single
// result into the output register once that register is free; the block then
// returns to idle and can take the next request. A spin reads the due-tick
// memory one slot per cycle, while the receiver does not stall, from slot 0
// up to the highest slot in use, then loads its done result and returns to
// idle for the next request. Each due slot gives one result ahead of the done.
// While the receiver stalls, the output holds its payload and the scan
// pauses on the due slot waiting to be reported.
// Reset clears the in-use marks, highest slot, spin tick, current slot and
// all handshake state; no clearing pass runs, so the block accepts a
// request as soon as reset is released.
module deadline_task_table_scheduler
    import dtts_pkg::*;
#(
    parameter int NUM_SLOTS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ID_W-1:0]   i_slot,
    input  logic              i_use_current,
    input  logic [TICK_W-1:0] i_tick_value,
    input  logic [TICK_W-1:0] i_now_tick,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [ID_W-1:0]   o_slot_id,
    output logic [ID_W-1:0]   o_current_slot,
    output logic [TICK_W-1:0] o_spin_tick_out,
    output logic              o_last
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int TW = (AW > ID_W) ? AW : ID_W;
    localparam logic [TW:0] SLOT_LIMIT = (TW + 1)'(NUM_SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_slot;
    logic              r_use_cur;
    logic [TICK_W-1:0] r_tv;
    logic [TICK_W-1:0] r_now;
    logic [TICK_W-1:0] r_spin_tick;
    logic [TICK_W-1:0] n_spin_tick;
    logic [AW-1:0]     r_current;
    logic [AW-1:0]     n_current;
    logic [CW-1:0]     r_rd_idx;
    logic [CW-1:0]     n_rd_idx;
    logic [AW-1:0]     r_cmp_idx;
    logic [AW-1:0]     n_cmp_idx;
    logic              r_cmp_v;
    logic              n_cmp_v;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [ID_W-1:0]   r_out_slot;
    logic [ID_W-1:0]   r_out_cur;
    logic [TICK_W-1:0] r_out_tick;
    logic              r_out_last;

    t_slot_cmd            map_cmd;
    logic [AW-1:0]        map_idx;
    logic [NUM_SLOTS-1:0] in_use;
    logic [AW-1:0]        highest;
    logic                 free_found;
    logic [AW-1:0]        free_idx;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TICK_W-1:0] wr_data;
    logic              rd_en;
    logic [TICK_W-1:0] rd_data;

    logic              accept;
    logic              out_free;
    logic [TW:0]       target;
    logic [TW:0]       slot_ext;
    logic              target_ok;
    logic              slot_ok;
    logic [TICK_W-1:0] plan_data;
    logic [TICK_W-1:0] add_base;
    logic              hit;
    logic              rd_ok;
    logic              emit;
    logic [KIND_W-1:0] e_kind;
    logic [AW-1:0]     e_slot;
    logic [AW-1:0]     e_cur;
    logic              e_last;
    logic [TW-1:0]     e_slot_ext;
    logic [TW-1:0]     e_cur_ext;

    dtts_slot_map #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_slot_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (map_cmd),
        .i_idx       (map_idx),
        .o_in_use    (in_use),
        .o_highest   (highest),
        .o_free_found(free_found),
        .o_free_idx  (free_idx)
    );

    dtts_due_mem #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_due_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_rd_idx[AW-1:0]),
        .o_rd_data(rd_data)
    );

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign target    = r_use_cur ? (TW + 1)'(r_current) : (TW + 1)'(r_slot);
    assign slot_ext  = (TW + 1)'(r_slot);
    assign target_ok = target < SLOT_LIMIT;
    assign slot_ok   = slot_ext < SLOT_LIMIT;
    assign hit       = r_cmp_v && in_use[r_cmp_idx] && (r_spin_tick >= rd_data);
    assign rd_ok     = r_rd_idx <= CW'(highest);
    assign add_base  = (r_op == OP_PLAN_REL) ? r_spin_tick : r_now;

    always_comb begin
        case (r_op)
            OP_PLAN_NOW: plan_data = '0;
            OP_PLAN_ABS: plan_data = r_tv;
            default:     plan_data = add_base + r_tv;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_spin_tick = r_spin_tick;
        n_current   = r_current;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_v     = r_cmp_v;
        map_cmd     = '0;
        map_idx     = free_idx;
        wr_en       = 1'b0;
        wr_addr     = r_cmp_idx;
        wr_data     = TICK_ALL_ONES;
        rd_en       = 1'b0;
        emit        = 1'b0;
        e_kind      = KIND_ACK;
        e_slot      = '0;
        e_cur       = r_current;
        e_last      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_SPIN) begin
                        n_spin_tick = i_now_tick;
                        n_rd_idx    = '0;
                        n_cmp_v     = 1'b0;
                        n_state     = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    case (r_op) inside
                        OP_REGISTER: begin
                            if (free_found) begin
                                map_cmd.claim = 1'b1;
                                wr_en         = 1'b1;
                                wr_addr       = free_idx;
                                wr_data       = r_tv;
                                e_kind        = KIND_REGISTERED;
                                e_slot        = free_idx;
                            end else begin
                                e_kind = KIND_FULL;
                            end
                        end
                        OP_UNREGISTER: begin
                            map_idx      = slot_ext[AW-1:0];
                            map_cmd.drop = slot_ok;
                        end
                        OP_PLAN_NOW, OP_PLAN_ABS, OP_PLAN_REL, OP_PLAN_FROM: begin
                            wr_en   = target_ok;
                            wr_addr = target[AW-1:0];
                            wr_data = plan_data;
                        end
                        default: begin
                            e_kind = KIND_ACK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!(hit && !out_free)) begin
                    if (hit) begin
                        wr_en     = 1'b1;
                        n_current = r_cmp_idx;
                        emit      = 1'b1;
                        e_kind    = KIND_DUE;
                        e_slot    = r_cmp_idx;
                        e_cur     = r_cmp_idx;
                        e_last    = 1'b0;
                    end
                    if (rd_ok) begin
                        rd_en     = 1'b1;
                        n_cmp_idx = r_rd_idx[AW-1:0];
                        n_cmp_v   = 1'b1;
                        n_rd_idx  = r_rd_idx + 1'b1;
                    end else begin
                        n_cmp_v = 1'b0;
                        if (!r_cmp_v) begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_DONE;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign e_slot_ext = TW'(e_slot);
    assign e_cur_ext  = TW'(e_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spin_tick <= '0;
            r_current   <= '0;
            r_rd_idx    <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_spin_tick <= n_spin_tick;
            r_current   <= n_current;
            r_rd_idx    <= n_rd_idx;
            r_cmp_v     <= n_cmp_v;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        if (accept) begin
            r_op      <= i_operation;
            r_slot    <= i_slot;
            r_use_cur <= i_use_current;
            r_tv      <= i_tick_value;
            r_now     <= i_now_tick;
        end
        if (emit) begin
            r_out_kind <= e_kind;
            r_out_slot <= e_slot_ext[ID_W-1:0];
            r_out_cur  <= e_cur_ext[ID_W-1:0];
            r_out_tick <= r_spin_tick;
            r_out_last <= e_last;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_slot_id       = r_out_slot;
    assign o_current_slot  = r_out_cur;
    assign o_spin_tick_out = r_out_tick;
    assign o_last          = r_out_last;

endmodule

// File: src/dtts_checker.sv
module dtts_checker
    import dtts_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [KIND_W-1:0] o_kind,
    input logic [ID_W-1:0]   o_slot_id,
    input logic              o_last
);

    a_reset_clears_output: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_out_valid
    ) else $error("Result valid after reset.");

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("Request channel open right after an accepted request.");

    a_last_matches_kind: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind != KIND_DUE))
    ) else $error("Last flag does not match result kind.");

    a_stalled_result_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_kind) && $stable(o_slot_id) && $stable(o_last))
    ) else $error("Stalled result changed.");

endmodule

bind deadline_task_table_scheduler dtts_checker u_dtts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_kind     (o_kind),
    .o_slot_id  (o_slot_id),
    .o_last     (o_last)
);
